### sv/idll_pkg.sv
// Shared codes, states and constants of the indexed doubly linked list.
`default_nettype none

package idll_pkg;

    // Request codes carried by the action field
    typedef enum logic [1:0] {
        ACT_INSERT_BEFORE = 2'd0,
        ACT_INSERT_AFTER  = 2'd1,
        ACT_REMOVE        = 2'd2,
        ACT_FIND          = 2'd3
    } action_t;

    // Completion codes carried by the status field
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_ANCHOR = 3'd1,
        ST_FULL       = 3'd2,
        ST_SENTINEL   = 3'd3,
        ST_POSITION   = 3'd4
    } status_t;

    // Request sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_RD1,
        S_RD2,
        S_W1,
        S_W2,
        S_WALK0,
        S_WALK,
        S_RESP
    } state_t;

    localparam int unsigned ELEM_W = 64;

    // Word written into an entry when it goes back to the free chain
    localparam logic [ELEM_W-1:0] POISON_WORD = 64'h0D00_DFBA_D8DE_ADDE;

endpackage

`default_nettype wire

### sv/idll_links.sv
// Next and prev link memories with the post-reset initialization sweep.
`default_nettype none

module idll_links #(
    parameter int CAPACITY = 64,
    localparam int DEPTH = CAPACITY + 1,
    localparam int IW = $clog2(CAPACITY + 1)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    output logic               busy,
    input  wire logic [IW-1:0] next_raddr,
    input  wire logic [IW-1:0] prev_raddr,
    output logic      [IW-1:0] next_rdata,
    output logic      [IW-1:0] prev_rdata,
    input  wire logic          next_we,
    input  wire logic [IW-1:0] next_waddr,
    input  wire logic [IW-1:0] next_wdata,
    input  wire logic          prev_we,
    input  wire logic [IW-1:0] prev_waddr,
    input  wire logic [IW-1:0] prev_wdata
);

    logic [IW-1:0] next_mem [DEPTH];
    logic [IW-1:0] prev_mem [DEPTH];

    logic          busy_reg;
    logic          busy_next;
    logic [IW-1:0] clr_reg;
    logic [IW-1:0] clr_next;

    logic          n_we;
    logic [IW-1:0] n_waddr;
    logic [IW-1:0] n_wdata;
    logic          p_we;
    logic [IW-1:0] p_waddr;
    logic [IW-1:0] p_wdata;

    logic [IW-1:0] next_rdata_reg;
    logic [IW-1:0] prev_rdata_reg;

    // Advance the sweep over every entry, then release the port
    always_comb
    begin
        busy_next = busy_reg;
        clr_next  = clr_reg;
        if (busy_reg)
        begin
            clr_next = clr_reg + IW'(1);
            if (clr_reg == IW'(CAPACITY))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            clr_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            clr_reg  <= clr_next;
        end
    end

    // Sweep writes the free chain i -> i+1 and clears prev; otherwise take the user port
    always_comb
    begin
        if (busy_reg)
        begin
            n_we    = 1'b1;
            n_waddr = clr_reg;
            if ((clr_reg == '0) || (clr_reg == IW'(CAPACITY)))
            begin
                n_wdata = '0;
            end
            else
            begin
                n_wdata = clr_reg + IW'(1);
            end
            p_we    = 1'b1;
            p_waddr = clr_reg;
            p_wdata = '0;
        end
        else
        begin
            n_we    = next_we;
            n_waddr = next_waddr;
            n_wdata = next_wdata;
            p_we    = prev_we;
            p_waddr = prev_waddr;
            p_wdata = prev_wdata;
        end
    end

    // Next link memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (n_we)
        begin
            next_mem[n_waddr] <= n_wdata;
        end
        next_rdata_reg <= next_mem[next_raddr];
    end

    // Prev link memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            prev_mem[p_waddr] <= p_wdata;
        end
        prev_rdata_reg <= prev_mem[prev_raddr];
    end

    assign busy       = busy_reg;
    assign next_rdata = next_rdata_reg;
    assign prev_rdata = prev_rdata_reg;

endmodule

`default_nettype wire

### sv/indexed_doubly_linked_list_top.sv
// Top level of the indexed doubly linked list with free chain allocation.
//
// Doubly linked list kept in a table of CAPACITY+1 entries, entry 0 being the sentinel whose
// next link is the head and prev link the tail; free entries form a chain from free_head.
// The next and prev links live in two synchronous memories with a registered read, read and
// written back by a small sequencer that serves one request at a time. After reset the link
// memories are initialized by a sweep over all CAPACITY+1 entries, during which in_stall is high.
// From IDLE, insert steps through RD1, RD2, W1, W2 and RESP, remove through RD1, W1, W2 and RESP,
// find through WALK0 and one WALK step per link walked (at most CAPACITY/2 rounded up, one
// memory read per link) to RESP, rejected requests and find of position zero straight to RESP.
// The result sits in an output register; a new request is taken while it waits for the consumer.
`default_nettype none

module indexed_doubly_linked_list_top #(
    parameter int CAPACITY = 64,
    localparam int DEPTH = CAPACITY + 1,
    localparam int IW = $clog2(CAPACITY + 1)
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [1:0]                 action,
    input  wire logic [IW-1:0]              anchor,
    input  wire logic [idll_pkg::ELEM_W-1:0] value,
    input  wire logic [IW-1:0]              position,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [IW-1:0]                   result_address,
    output logic [2:0]                      status,
    output logic [IW-1:0]                   count
);

    // Sequencer and list bookkeeping
    idll_pkg::state_t  state_reg;
    idll_pkg::state_t  state_next;
    logic [DEPTH-1:0]  in_use_reg;
    logic [DEPTH-1:0]  in_use_next;
    logic [IW-1:0]     free_head_reg;
    logic [IW-1:0]     free_head_next;
    logic [IW-1:0]     cnt_reg;
    logic [IW-1:0]     cnt_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    // Request payload and working values
    idll_pkg::action_t act_reg;
    idll_pkg::action_t act_next;
    logic [IW-1:0]     anc_reg;
    logic [IW-1:0]     anc_next;
    logic [idll_pkg::ELEM_W-1:0] val_reg;
    logic [idll_pkg::ELEM_W-1:0] val_next;
    logic              dir_reg;
    logic              dir_next;
    logic [IW-1:0]     rem_reg;
    logic [IW-1:0]     rem_next;
    logic [IW-1:0]     left_reg;
    logic [IW-1:0]     left_next;
    logic [IW-1:0]     right_reg;
    logic [IW-1:0]     right_next;
    logic [IW-1:0]     fnext_reg;
    logic [IW-1:0]     fnext_next;
    logic [IW-1:0]     res_reg;
    logic [IW-1:0]     res_next;
    idll_pkg::status_t st_reg;
    idll_pkg::status_t st_next;
    logic [IW-1:0]     result_out_reg;
    logic [2:0]        status_out_reg;
    logic [IW-1:0]     count_out_reg;

    // Element store
    logic [idll_pkg::ELEM_W-1:0] elem_mem [DEPTH];
    logic                        elem_we;
    logic [IW-1:0]               elem_waddr;
    logic [idll_pkg::ELEM_W-1:0] elem_wdata;

    // Link memory port
    logic          links_busy;
    logic [IW-1:0] next_raddr;
    logic [IW-1:0] prev_raddr;
    logic [IW-1:0] next_rdata;
    logic [IW-1:0] prev_rdata;
    logic          next_we;
    logic [IW-1:0] next_waddr;
    logic [IW-1:0] next_wdata;
    logic          prev_we;
    logic [IW-1:0] prev_waddr;
    logic [IW-1:0] prev_wdata;

    // Request decode
    logic              accept;
    logic              out_free;
    idll_pkg::action_t req_act;
    logic              anchor_ok;
    logic              find_fwd;
    logic [IW-1:0]     find_steps;
    idll_pkg::state_t  disp_state;
    idll_pkg::status_t disp_status;
    logic              is_insert;
    logic              is_before;
    logic [IW-1:0]     walk_cur;

    idll_links #(
        .CAPACITY (CAPACITY)
    ) u_links (
        .clk        (clk),
        .rst_n      (rst_n),
        .busy       (links_busy),
        .next_raddr (next_raddr),
        .prev_raddr (prev_raddr),
        .next_rdata (next_rdata),
        .prev_rdata (prev_rdata),
        .next_we    (next_we),
        .next_waddr (next_waddr),
        .next_wdata (next_wdata),
        .prev_we    (prev_we),
        .prev_waddr (prev_waddr),
        .prev_wdata (prev_wdata)
    );

    assign in_stall = (state_reg != idll_pkg::S_IDLE) || links_busy;
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign req_act    = idll_pkg::action_t'(action);
    assign anchor_ok  = (anchor <= IW'(CAPACITY)) && in_use_reg[anchor];
    assign find_fwd   = (position <= (cnt_reg >> 1));
    assign find_steps = find_fwd ? position : (cnt_reg - position + IW'(1));

    assign is_insert = (act_reg != idll_pkg::ACT_REMOVE);
    assign is_before = (act_reg == idll_pkg::ACT_INSERT_BEFORE);
    assign walk_cur  = dir_reg ? prev_rdata : next_rdata;

    // Check the request and pick where the sequencer goes first
    always_comb
    begin
        disp_state  = idll_pkg::S_RESP;
        disp_status = idll_pkg::ST_OK;
        if (req_act == idll_pkg::ACT_FIND)
        begin
            if (position > cnt_reg)
            begin
                disp_status = idll_pkg::ST_POSITION;
            end
            else if (find_steps != '0)
            begin
                disp_state = idll_pkg::S_WALK0;
            end
        end
        else if (!anchor_ok)
        begin
            disp_status = idll_pkg::ST_BAD_ANCHOR;
        end
        else if (req_act == idll_pkg::ACT_REMOVE)
        begin
            if (anchor == '0)
            begin
                disp_status = idll_pkg::ST_SENTINEL;
            end
            else
            begin
                disp_state = idll_pkg::S_RD1;
            end
        end
        else if (free_head_reg == '0)
        begin
            disp_status = idll_pkg::ST_FULL;
        end
        else
        begin
            disp_state = idll_pkg::S_RD1;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            idll_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = disp_state;
                end
            end
            idll_pkg::S_RD1:
            begin
                state_next = is_insert ? idll_pkg::S_RD2 : idll_pkg::S_W1;
            end
            idll_pkg::S_RD2:
            begin
                state_next = idll_pkg::S_W1;
            end
            idll_pkg::S_W1:
            begin
                state_next = idll_pkg::S_W2;
            end
            idll_pkg::S_W2:
            begin
                state_next = idll_pkg::S_RESP;
            end
            idll_pkg::S_WALK0:
            begin
                state_next = idll_pkg::S_WALK;
            end
            idll_pkg::S_WALK:
            begin
                if (rem_reg == IW'(1))
                begin
                    state_next = idll_pkg::S_RESP;
                end
            end
            idll_pkg::S_RESP:
            begin
                if (out_free)
                begin
                    state_next = idll_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = idll_pkg::S_IDLE;
            end
        endcase
    end

    // Memory accesses and working register updates per state
    always_comb
    begin
        next_raddr     = anc_reg;
        prev_raddr     = anc_reg;
        next_we        = 1'b0;
        next_waddr     = '0;
        next_wdata     = '0;
        prev_we        = 1'b0;
        prev_waddr     = '0;
        prev_wdata     = '0;
        elem_we        = 1'b0;
        elem_waddr     = '0;
        elem_wdata     = val_reg;
        in_use_next    = in_use_reg;
        free_head_next = free_head_reg;
        cnt_next       = cnt_reg;
        act_next       = act_reg;
        anc_next       = anc_reg;
        val_next       = val_reg;
        dir_next       = dir_reg;
        rem_next       = rem_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        fnext_next     = fnext_reg;
        res_next       = res_reg;
        st_next        = st_reg;
        case (state_reg)
            idll_pkg::S_IDLE:
            begin
                // Latch the request and its check result
                if (accept)
                begin
                    act_next = req_act;
                    anc_next = anchor;
                    val_next = value;
                    dir_next = !find_fwd;
                    rem_next = find_steps;
                    res_next = '0;
                    st_next  = disp_status;
                end
            end
            idll_pkg::S_RD1:
            begin
                // Insert reads free head's next, anchor's prev; remove reads both anchor links
                if (is_insert)
                begin
                    next_raddr = free_head_reg;
                end
            end
            idll_pkg::S_RD2:
            begin
                // Hold the new free head; read the anchor's next link
                fnext_next = next_rdata;
            end
            idll_pkg::S_W1:
            begin
                if (is_insert)
                begin
                    // Link the new entry between its left and right neighbors
                    left_next  = is_before ? prev_rdata : anc_reg;
                    right_next = is_before ? anc_reg : next_rdata;
                    next_we    = 1'b1;
                    next_waddr = free_head_reg;
                    next_wdata = is_before ? anc_reg : next_rdata;
                    prev_we    = 1'b1;
                    prev_waddr = free_head_reg;
                    prev_wdata = is_before ? prev_rdata : anc_reg;
                    elem_we    = 1'b1;
                    elem_waddr = free_head_reg;
                    elem_wdata = val_reg;
                end
                else
                begin
                    // Bridge the neighbors of the removed entry
                    next_we    = 1'b1;
                    next_waddr = prev_rdata;
                    next_wdata = next_rdata;
                    prev_we    = 1'b1;
                    prev_waddr = next_rdata;
                    prev_wdata = prev_rdata;
                end
            end
            idll_pkg::S_W2:
            begin
                if (is_insert)
                begin
                    // Point the neighbors at the new entry and pop the free chain
                    next_we                   = 1'b1;
                    next_waddr                = left_reg;
                    next_wdata                = free_head_reg;
                    prev_we                   = 1'b1;
                    prev_waddr                = right_reg;
                    prev_wdata                = free_head_reg;
                    in_use_next[free_head_reg] = 1'b1;
                    free_head_next            = fnext_reg;
                    cnt_next                  = cnt_reg + IW'(1);
                    res_next                  = free_head_reg;
                end
                else
                begin
                    // Push the removed entry onto the free chain and poison it
                    next_we             = 1'b1;
                    next_waddr          = anc_reg;
                    next_wdata          = free_head_reg;
                    prev_we             = 1'b1;
                    prev_waddr          = anc_reg;
                    prev_wdata          = '0;
                    elem_we             = 1'b1;
                    elem_waddr          = anc_reg;
                    elem_wdata          = idll_pkg::POISON_WORD;
                    in_use_next[anc_reg] = 1'b0;
                    free_head_next      = anc_reg;
                    cnt_next            = cnt_reg - IW'(1);
                end
            end
            idll_pkg::S_WALK0:
            begin
                // Start the walk at the sentinel
                next_raddr = '0;
                prev_raddr = '0;
            end
            idll_pkg::S_WALK:
            begin
                // Follow one link per cycle
                next_raddr = walk_cur;
                prev_raddr = walk_cur;
                rem_next   = rem_reg - IW'(1);
                if (rem_reg == IW'(1))
                begin
                    res_next = walk_cur;
                end
            end
            idll_pkg::S_RESP:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Load the output register when it is free; drop valid after a transfer
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if ((state_reg == idll_pkg::S_RESP) && out_free)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= idll_pkg::S_IDLE;
            in_use_reg    <= DEPTH'(1);
            free_head_reg <= IW'(1);
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_use_reg    <= in_use_next;
            free_head_reg <= free_head_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        act_reg   <= act_next;
        anc_reg   <= anc_next;
        val_reg   <= val_next;
        dir_reg   <= dir_next;
        rem_reg   <= rem_next;
        left_reg  <= left_next;
        right_reg <= right_next;
        fnext_reg <= fnext_next;
        res_reg   <= res_next;
        st_reg    <= st_next;
        if ((state_reg == idll_pkg::S_RESP) && out_free)
        begin
            result_out_reg <= res_reg;
            status_out_reg <= st_reg;
            count_out_reg  <= cnt_reg;
        end
    end

    // Element store: written on insert and on remove
    always_ff @(posedge clk)
    begin
        if (elem_we)
        begin
            elem_mem[elem_waddr] <= elem_wdata;
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_address = result_out_reg;
    assign status         = status_out_reg;
    assign count          = count_out_reg;

    // The free chain is empty exactly when every entry is linked
    assert property (@(posedge clk) disable iff (!rst_n)
        (free_head_reg == '0) == (cnt_reg == IW'(CAPACITY)))
        else $error("free head and entry count disagree");

    // Entries in use are the linked ones plus the sentinel
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(in_use_reg) == (int'(cnt_reg) + 1))
        else $error("in-use flags and entry count disagree");

    // A walk never runs with no steps left
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == idll_pkg::S_WALK) |-> (rem_reg != '0))
        else $error("walk step counter underflow");

    // A new result appears only out of the response state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == idll_pkg::S_RESP))
        else $error("result presented outside the response state");

endmodule

`default_nettype wire
